// File: rtl/snqm_pkg.sv
// Shared types, codes and default sizes for the named stack/queue manager.
// Depends on nothing; every other file of the block imports it.

package snqm_pkg;

    // Default sizes of the list table, of each list and of a stored word.
    localparam int DEF_NUM_LISTS  = 16;
    localparam int DEF_LIST_DEPTH = 16;
    localparam int DEF_VALUE_BITS = 64;

    // Fixed field widths of the channels.
    localparam int KEY_BITS  = 16;
    localparam int WORD_BITS = 64;

    // Command codes.
    typedef enum logic [1:0] {
        FUNC_CREATE_STACK = 2'd0,
        FUNC_CREATE_QUEUE = 2'd1,
        FUNC_PUSH         = 2'd2,
        FUNC_POP          = 2'd3
    } func_t;

    // Status codes returned with every result word.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Outcome of one command as decided by the slot table.
    typedef struct packed {
        status_t status;
        logic    wr_en;
        logic    rd_en;
    } access_t;

    // Number of bits that index n entries, at least one.
    function automatic int index_bits(input int n);
        int bits;
        bits = (n > 1) ? $clog2(n) : 1;
        return bits;
    endfunction

endpackage

// File: rtl/snqm_cmd_if.sv
// Command channel of the named stack/queue manager: valid/ready and the command word.
// Depends on snqm_pkg.

interface snqm_cmd_if
    import snqm_pkg::*;
    ();

    logic                 valid;
    logic                 ready;
    func_t                func;
    logic [KEY_BITS-1:0]  list_key;
    logic [WORD_BITS-1:0] push_value;

    modport source (output valid, output func, output list_key, output push_value,
                    input ready);
    modport sink   (input valid, input func, input list_key, input push_value,
                    output ready);

endinterface

// File: rtl/snqm_rsp_if.sv
// Result channel of the named stack/queue manager: valid/ready and the result word.
// Depends on snqm_pkg.

interface snqm_rsp_if
    import snqm_pkg::*;
    ();

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic                 value_valid;
    logic [WORD_BITS-1:0] popped_value;

    modport source (output valid, output status, output value_valid, output popped_value,
                    input ready);
    modport sink   (input valid, input status, input value_valid, input popped_value,
                    output ready);

endinterface

// File: rtl/snqm_ram.sv
// Generic single-port RAM with a registered read port.
// Depends on snqm_pkg for default sizes and the address width helper.

module snqm_ram
    import snqm_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS,
    parameter int DEPTH = DEF_NUM_LISTS * DEF_LIST_DEPTH
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic                        we,
    input  logic [index_bits(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]            wdata,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on a write access; the read register holds between reads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/snqm_slot_table.sv
// Slot table of the named stack/queue manager: key match, free slot search,
// ring pointers and the entry address of each command. Depends on snqm_pkg.

module snqm_slot_table
    import snqm_pkg::*;
#(
    parameter int NUM_LISTS  = DEF_NUM_LISTS,
    parameter int LIST_DEPTH = DEF_LIST_DEPTH
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      step,
    input  func_t                                     func,
    input  logic [KEY_BITS-1:0]                       key,
    output access_t                                   acc,
    output logic [index_bits(NUM_LISTS*LIST_DEPTH)-1:0] addr
);

    localparam int SLOT_W = index_bits(NUM_LISTS);
    localparam int POS_W  = index_bits(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = index_bits(NUM_LISTS * LIST_DEPTH);

    logic                slot_used_reg  [NUM_LISTS];
    logic [KEY_BITS-1:0] slot_key_reg   [NUM_LISTS];
    logic                slot_queue_reg [NUM_LISTS];
    logic [POS_W-1:0]    slot_front_reg [NUM_LISTS];
    logic [CNT_W-1:0]    slot_count_reg [NUM_LISTS];

    logic [NUM_LISTS-1:0] hit_vec;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_idx;
    logic                 free_any;
    logic [SLOT_W-1:0]    free_idx;
    logic [POS_W-1:0]     sel_front;
    logic [CNT_W-1:0]     sel_count;
    logic                 sel_queue;
    logic [SUM_W-1:0]     tail_sum;
    logic [POS_W-1:0]     tail_pos;
    logic [POS_W-1:0]     prev_pos;
    logic [POS_W-1:0]     next_pos;
    logic [POS_W-1:0]     push_pos;
    logic [POS_W-1:0]     acc_pos;
    logic                 do_create;
    logic                 do_push;
    logic                 do_pop;

    // Compare the key against every used slot at once; keys are unique.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            hit_vec[i] = slot_used_reg[i] && (slot_key_reg[i] == key);
            if (hit_vec[i])
            begin
                hit_idx = hit_idx | SLOT_W'(i);
            end
        end
        hit = |hit_vec;
    end

    // Lowest free slot for a new list.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign sel_front = slot_front_reg[hit_idx];
    assign sel_count = slot_count_reg[hit_idx];
    assign sel_queue = slot_queue_reg[hit_idx];

    // Ring positions: queue tail, stack front after a push, front after a pop.
    always_comb
    begin
        tail_sum = SUM_W'(sel_front) + SUM_W'(sel_count);
        if (tail_sum >= SUM_W'(LIST_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(LIST_DEPTH);
        end
        tail_pos = POS_W'(tail_sum);
        prev_pos = (sel_front == '0) ? POS_W'(LIST_DEPTH - 1) : sel_front - POS_W'(1);
        next_pos = (sel_front == POS_W'(LIST_DEPTH - 1)) ? '0 : sel_front + POS_W'(1);
        push_pos = sel_queue ? tail_pos : prev_pos;
    end

    // Decode the command into a status and the entry access it needs.
    always_comb
    begin
        acc.status = ST_OK;
        do_create  = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        acc_pos    = sel_front;
        unique case (func)
            FUNC_CREATE_STACK, FUNC_CREATE_QUEUE:
            begin
                if (hit)
                begin
                    acc.status = ST_EXISTS;
                end
                else if (!free_any)
                begin
                    acc.status = ST_FULL;
                end
                else
                begin
                    do_create = 1'b1;
                end
            end
            FUNC_PUSH:
            begin
                acc_pos = push_pos;
                if (!hit)
                begin
                    acc.status = ST_MISSING;
                end
                else if (sel_count == CNT_W'(LIST_DEPTH))
                begin
                    acc.status = ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (!hit)
                begin
                    acc.status = ST_MISSING;
                end
                else if (sel_count == '0)
                begin
                    acc.status = ST_EMPTY;
                end
                else
                begin
                    do_pop = 1'b1;
                end
            end
        endcase
        acc.wr_en = step && do_push;
        acc.rd_en = step && do_pop;
    end

    // Each list owns a block of LIST_DEPTH entries in the entry store.
    assign addr = ADDR_W'(hit_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(acc_pos);

    // Slot occupancy flags are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                slot_used_reg[i] <= 1'b0;
            end
        end
        else if (step && do_create)
        begin
            slot_used_reg[free_idx] <= 1'b1;
        end
    end

    // Slot contents are meaningful only while the slot is in use.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (do_create)
            begin
                slot_key_reg[free_idx]   <= key;
                slot_queue_reg[free_idx] <= (func == FUNC_CREATE_QUEUE);
                slot_front_reg[free_idx] <= '0;
                slot_count_reg[free_idx] <= '0;
            end
            else if (do_push)
            begin
                slot_count_reg[hit_idx] <= sel_count + CNT_W'(1);
                if (!sel_queue)
                begin
                    slot_front_reg[hit_idx] <= prev_pos;
                end
            end
            else if (do_pop)
            begin
                slot_count_reg[hit_idx] <= sel_count - CNT_W'(1);
                slot_front_reg[hit_idx] <= next_pos;
            end
        end
    end

endmodule

// File: rtl/named_stack_queue_manager.sv
// Named stack/queue manager: a table of lists, each a stack or a queue, named by 16-bit keys.
// Depends on snqm_pkg, snqm_cmd_if, snqm_rsp_if, snqm_slot_table and snqm_ram.

// The block accepts one command word per clock cycle while the result channel is not
// stalled, and returns exactly one result word for each, in order. A command first waits
// in the input register; from there the slot table matches the key against all lists at
// once, updates the list's pointers and issues a single access to the entry store, whose
// read is registered alongside the result register. The entry store holds NUM_LISTS *
// LIST_DEPTH words of VALUE_BITS bits in one single-port memory; pushed words keep only
// their low VALUE_BITS bits. Reset clears the list table at once, so no clearing pass is
// needed and the block takes commands directly after reset. A stalled result holds the
// pipeline; one further command then waits in the input register and the command channel
// stalls until the result word is taken.

module named_stack_queue_manager
    import snqm_pkg::*;
#(
    parameter int NUM_LISTS  = DEF_NUM_LISTS,
    parameter int LIST_DEPTH = DEF_LIST_DEPTH,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    snqm_cmd_if.sink  cmd,
    snqm_rsp_if.source rsp
);

    localparam int RAM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_W    = index_bits(RAM_DEPTH);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    func_t                 s1_func_reg;
    logic [KEY_BITS-1:0]   s1_key_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;

    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    status_t               s2_status_reg;
    logic                  s2_pop_reg;

    logic                  advance;
    logic                  cmd_take;
    access_t               acc;
    logic [ADDR_W-1:0]     ram_addr;
    logic [VALUE_BITS-1:0] ram_rdata;

    // The command moves on when the result register is free or being emptied.
    assign advance  = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_take = cmd.valid && cmd.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    // Pipeline occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input register and result register contents.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_func_reg  <= cmd.func;
            s1_key_reg   <= cmd.list_key;
            s1_value_reg <= cmd.push_value[VALUE_BITS-1:0];
        end
        if (advance)
        begin
            s2_status_reg <= acc.status;
            s2_pop_reg    <= acc.rd_en;
        end
    end

    // List table: key match, pointer update and entry address.
    snqm_slot_table #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_slot_table (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .func  (s1_func_reg),
        .key   (s1_key_reg),
        .acc   (acc),
        .addr  (ram_addr)
    );

    // Entry store shared by all lists; the read register holds while the result stalls.
    snqm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .en    (acc.wr_en || acc.rd_en),
        .we    (acc.wr_en),
        .addr  (ram_addr),
        .wdata (s1_value_reg),
        .rdata (ram_rdata)
    );

    // Result word.
    assign rsp.valid        = s2_valid_reg;
    assign rsp.status       = s2_status_reg;
    assign rsp.value_valid  = s2_pop_reg;
    assign rsp.popped_value = s2_pop_reg ? WORD_BITS'(ram_rdata) : '0;

endmodule

// File: tb/snqm_checker.sv
`timescale 1ns / 100ps
// Checker for the named stack/queue manager. It watches the command and result channels,
// predicts each result word from its own copy of the list table and compares field by field.
// Depends on snqm_pkg, snqm_cmd_if and snqm_rsp_if.

module snqm_checker
    import snqm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    snqm_cmd_if  cmd,
    snqm_rsp_if  rsp,
    output int   mismatches,
    output int   pending_words
);

    typedef struct packed {
        status_t              status;
        logic                 value_valid;
        logic [WORD_BITS-1:0] popped_value;
    } result_word_t;

    // Only the low VALUE_BITS bits of a pushed word are stored.
    localparam logic [WORD_BITS-1:0] KEEP_MASK =
        {WORD_BITS{1'b1}} >> (WORD_BITS - DEF_VALUE_BITS);

    // Shadow copy of the list table and of the entry store.
    logic                 list_used  [DEF_NUM_LISTS];
    logic [KEY_BITS-1:0]  list_name  [DEF_NUM_LISTS];
    logic                 list_fifo  [DEF_NUM_LISTS];
    int                   list_head  [DEF_NUM_LISTS];
    int                   list_fill  [DEF_NUM_LISTS];
    logic [WORD_BITS-1:0] list_words [DEF_NUM_LISTS][DEF_LIST_DEPTH];

    // Result words still owed by the block, oldest first.
    result_word_t owed_results[$];

    // Applies one command to the shadow table and returns the result word it should yield.
    function automatic result_word_t execute_command(input func_t op,
                                                     input logic [KEY_BITS-1:0] key,
                                                     input logic [WORD_BITS-1:0] value);
        int           s;
        int           hit;
        int           free_slot;
        int           pos;
        result_word_t res;

        res.status       = ST_OK;
        res.value_valid  = 1'b0;
        res.popped_value = '0;
        hit       = -1;
        free_slot = -1;

        // Key match across every list, and the lowest free slot.
        for (s = 0; s < DEF_NUM_LISTS; s++)
        begin
            if (list_used[s] && list_name[s] == key && hit < 0)
                hit = s;
            if (!list_used[s] && free_slot < 0)
                free_slot = s;
        end

        if (op == FUNC_CREATE_STACK || op == FUNC_CREATE_QUEUE)
        begin
            if (hit >= 0)
                res.status = ST_EXISTS;
            else if (free_slot < 0)
                res.status = ST_FULL;
            else
            begin
                list_used[free_slot] = 1'b1;
                list_name[free_slot] = key;
                list_fifo[free_slot] = (op == FUNC_CREATE_QUEUE);
                list_head[free_slot] = 0;
                list_fill[free_slot] = 0;
            end
        end
        else if (hit < 0)
            res.status = ST_MISSING;
        else if (op == FUNC_PUSH)
        begin
            if (list_fill[hit] >= DEF_LIST_DEPTH)
                res.status = ST_FULL;
            else
            begin
                // A queue appends behind its last word; a stack moves its front back by one.
                if (list_fifo[hit])
                    pos = (list_head[hit] + list_fill[hit]) % DEF_LIST_DEPTH;
                else
                begin
                    pos = (list_head[hit] + DEF_LIST_DEPTH - 1) % DEF_LIST_DEPTH;
                    list_head[hit] = pos;
                end
                list_words[hit][pos] = value & KEEP_MASK;
                list_fill[hit]++;
            end
        end
        else
        begin
            if (list_fill[hit] == 0)
                res.status = ST_EMPTY;
            else
            begin
                res.value_valid  = 1'b1;
                res.popped_value = list_words[hit][list_head[hit]];
                list_head[hit]   = (list_head[hit] + 1) % DEF_LIST_DEPTH;
                list_fill[hit]--;
            end
        end
        return res;
    endfunction

    // Compare returned words against the oldest prediction, then predict newly accepted commands.
    always @(posedge clk or negedge rst_n)
    begin : watch
        int           i;
        result_word_t want;
        result_word_t got;

        if (!rst_n)
        begin
            for (i = 0; i < DEF_NUM_LISTS; i++)
                list_used[i] = 1'b0;
            owed_results.delete();
            mismatches    = 0;
            pending_words = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status       = rsp.status;
                got.value_valid  = rsp.value_valid;
                got.popped_value = rsp.popped_value;
                if (owed_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result word: status %0d valid %0b value %h",
                                 $time, got.status, got.value_valid, got.popped_value);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status || got.value_valid !== want.value_valid ||
                        got.popped_value !== want.popped_value)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: expected %0d/%0b/%h, got %0d/%0b/%h",
                                     $time, want.status, want.value_valid, want.popped_value,
                                     got.status, got.value_valid, got.popped_value);
                        mismatches++;
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                owed_results.push_back(execute_command(cmd.func, cmd.list_key, cmd.push_value));

            pending_words = owed_results.size();
        end
    end

endmodule

// File: tb/named_stack_queue_manager_test.sv
`timescale 1ns / 100ps
// Top of the named stack/queue manager testbench: clock, reset, command stimulus and verdict.
// Depends on snqm_pkg, both channel interfaces, the block itself and snqm_checker.

module named_stack_queue_manager_test
    import snqm_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 20;
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending_words;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_requests  = 0;
    int   hold_served    = 0;
    int   hold_left      = 0;

    // Keys that the random traffic keeps returning to, so that lists fill up and drain.
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

    snqm_cmd_if cmd ();
    snqm_rsp_if rsp ();

    named_stack_queue_manager dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    snqm_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit for a hung run.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready = 1'b0;
            end
            else
                rsp.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [WORD_BITS-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one command word after an optional random gap and returns once it is taken.
    task automatic send_command(input func_t op, input logic [KEY_BITS-1:0] key,
                                input logic [WORD_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid = 1'b0;
            @(negedge clk);
        end
        cmd.valid      = 1'b1;
        cmd.func       = op;
        cmd.list_key   = key;
        cmd.push_value = value;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering words until every predicted result has come back.
    task automatic drain_results();
        cmd.valid = 1'b0;
        while (pending_words != 0)
            @(negedge clk);
    endtask

    // Random traffic: mostly runs of pushes or pops on pooled keys, some creates, some noise.
    task automatic random_traffic(input int count);
        int                  sent;
        int                  pick;
        int                  burst;
        logic [KEY_BITS-1:0] key;
        func_t               op;

        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            key  = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick < 8)
            begin
                // Any command on any key; such keys are nearly always unknown.
                send_command(func_t'($urandom_range(3)), KEY_BITS'($urandom), random_word());
                sent++;
            end
            else if (pick < 20)
            begin
                op = ($urandom_range(1) == 0) ? FUNC_CREATE_STACK : FUNC_CREATE_QUEUE;
                send_command(op, key, random_word());
                sent++;
            end
            else
            begin
                // A run long enough to fill a list to overflow or empty it completely.
                op    = ($urandom_range(99) < 55) ? FUNC_PUSH : FUNC_POP;
                burst = $urandom_range(24, 1);
                repeat (burst)
                begin
                    send_command(op, key, random_word());
                    sent++;
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [WORD_BITS-1:0] first_word;
        logic [WORD_BITS-1:0] second_word;
        logic [WORD_BITS-1:0] third_word;

        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.func       = FUNC_CREATE_STACK;
        cmd.list_key   = '0;
        cmd.push_value = '0;
        foreach (key_pool[i])
            key_pool[i] = KEY_BITS'($urandom);
        first_word  = random_word();
        second_word = random_word();
        third_word  = random_word();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Unknown keys, creation at the key extremes and duplicate names.
        send_command(FUNC_POP, '0, '1);
        send_command(FUNC_PUSH, '1, '1);
        send_command(FUNC_CREATE_STACK, '0, '1);
        send_command(FUNC_CREATE_QUEUE, '1, '0);
        send_command(FUNC_CREATE_STACK, '0, '0);
        send_command(FUNC_CREATE_QUEUE, '1, '1);

        // Stack order, extreme values and popping an empty stack.
        send_command(FUNC_POP, '0, '0);
        send_command(FUNC_PUSH, '0, '0);
        send_command(FUNC_PUSH, '0, '1);
        send_command(FUNC_POP, '0, '0);
        send_command(FUNC_POP, '0, '1);
        send_command(FUNC_POP, '0, '0);

        // Queue order and popping an empty queue.
        send_command(FUNC_PUSH, '1, first_word);
        send_command(FUNC_PUSH, '1, second_word);
        send_command(FUNC_PUSH, '1, third_word);
        send_command(FUNC_POP, '1, '0);
        send_command(FUNC_POP, '1, '0);
        send_command(FUNC_POP, '1, '0);
        send_command(FUNC_POP, '1, '0);
        drain_results();

        // No idling, with one long hold-off on the result side while words keep coming.
        random_traffic(170);
        hold_requests++;
        random_traffic(40);
        drain_results();

        send_idle_pct  = 61;
        recv_stall_pct = 0;
        random_traffic(210);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 61;
        random_traffic(210);
        drain_results();

        send_idle_pct  = 26;
        recv_stall_pct = 26;
        random_traffic(210);
        drain_results();

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
